@@ rtl/drt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drt_pkg: shared types and constants of the dirty rectangle tracker
// Rectangle record, action and register codes, sequencer states.
// ----------------------------------------------------------------------------
package drt_pkg;

   localparam int CoordW = 12;

   typedef struct packed {
      logic [CoordW-1:0] x;
      logic [CoordW-1:0] y;
      logic [CoordW-1:0] w;
      logic [CoordW-1:0] h;
   } rect_type;

   typedef enum logic [1:0] {
      ACT_INVALIDATE = 2'd0,
      ACT_FLUSH      = 2'd1,
      ACT_DISCARD    = 2'd2,
      ACT_NONE       = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      REG_SCREEN_WIDTH  = 2'd0,
      REG_SCREEN_HEIGHT = 2'd1,
      REG_MERGE_GAP     = 2'd2,
      REG_TRACKING      = 2'd3
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLIP,
      ST_HOLD_SCAN,
      ST_APPEND,
      ST_COST_RD,
      ST_COST_MUL,
      ST_COST_CMP,
      ST_MERGE,
      ST_PAIR_RD,
      ST_PAIR_EVAL,
      ST_PAIR_MOVE,
      ST_FLUSH_RD,
      ST_FLUSH_EMIT
   } state_type;

   // result of comparing two rectangles on the shared unit
   typedef struct packed {
      logic a_holds_b;
      logic b_holds_a;
      logic near;
   } pair_rel_type;

   localparam logic [31:0] CostInit = 32'h7FFF_FFFF;

endpackage

@@ rtl/drt_geom.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drt_geom: shared geometry unit
// Containment, nearness and union of two rectangles, one pair per cycle.
// ----------------------------------------------------------------------------
module drt_geom
   import drt_pkg::*;
(
   input  rect_type         a,
   input  rect_type         b,
   input  logic [7:0]       merge_gap,
   output pair_rel_type     rel,
   output rect_type         uni
);

   logic [12:0] ax2, bx2, ay2, by2, ux2, uy2;
   logic [11:0] ux, uy;
   logic [12:0] gx, gy;

   assign ax2 = {1'b0, a.x} + {1'b0, a.w};
   assign bx2 = {1'b0, b.x} + {1'b0, b.w};
   assign ay2 = {1'b0, a.y} + {1'b0, a.h};
   assign by2 = {1'b0, b.y} + {1'b0, b.h};

   always_comb begin
      rel.a_holds_b = (b.x >= a.x) && (bx2 <= ax2) && (b.y >= a.y) && (by2 <= ay2);
      rel.b_holds_a = (a.x >= b.x) && (ax2 <= bx2) && (a.y >= b.y) && (ay2 <= by2);
      if (ax2 < {1'b0, b.x}) gx = {1'b0, b.x} - ax2;
      else if (bx2 < {1'b0, a.x}) gx = {1'b0, a.x} - bx2;
      else gx = '0;
      if (ay2 < {1'b0, b.y}) gy = {1'b0, b.y} - ay2;
      else if (by2 < {1'b0, a.y}) gy = {1'b0, a.y} - by2;
      else gy = '0;
      rel.near = ((gx == '0) && (gy == '0))
               || ((gx <= {5'd0, merge_gap}) && (gy == '0))
               || ((gy <= {5'd0, merge_gap}) && (gx == '0));
      ux  = (a.x < b.x) ? a.x : b.x;
      uy  = (a.y < b.y) ? a.y : b.y;
      ux2 = (ax2 > bx2) ? ax2 : bx2;
      uy2 = (ay2 > by2) ? ay2 : by2;
      uni.x = ux;
      uni.y = uy;
      uni.w = 12'(ux2 - {1'b0, ux});
      uni.h = 12'(uy2 - {1'b0, uy});
   end

endmodule

@@ rtl/dirty_rect_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dirty_rect_tracker: table of screen rectangles awaiting redraw
// Clips, stores, merges and flushes invalidated rectangles.
// ----------------------------------------------------------------------------
// One shared geometry unit is stepped by a sequencer over the slot table. An
// invalidate runs the containment scan plus, when the table is full, an area
// cost pass over every slot, then a compaction pass, restarted after each
// change. A flush walks every slot, adding a trailing beat when the final
// two beats leave back to back, and emits one rectangle per strobe; a
// discard clears the table. busy covers the sequencer and the pending
// trailing beat, but the registered final strobe arrives after busy falls;
// results are not held off, each rsp_valid pulse is one beat.
module dirty_rect_tracker
   import drt_pkg::*;
#(
   parameter int RECT_SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [15:0] req_rect_x,
   input  logic [15:0] req_rect_y,
   input  logic [15:0] req_rect_w,
   input  logic [15:0] req_rect_h,
   output logic        rsp_valid,
   output logic [11:0] rsp_out_x,
   output logic [11:0] rsp_out_y,
   output logic [11:0] rsp_out_w,
   output logic [11:0] rsp_out_h,
   output logic        rsp_out_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data
);

   localparam int IdxW = (RECT_SLOTS > 1) ? $clog2(RECT_SLOTS) : 1;
   localparam int CntW = $clog2(RECT_SLOTS + 1);

   state_type state_ff, state_in;

   rect_type slots_ff [RECT_SLOTS];
   logic [CntW-1:0] count_ff, count_in;
   logic [11:0] sw_ff, sh_ff;
   logic [7:0]  gap_ff;
   logic        en_ff;

   logic [IdxW-1:0] i_ff, i_in, j_ff, j_in, best_ff, best_in;
   rect_type a_ff, a_in, b_ff, b_in, new_ff, new_in;
   logic [31:0] best_cost_ff, best_cost_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] old_area_ff, old_area_in;
   logic        have_ff, have_in;

   logic        wr_en;
   logic [IdxW-1:0] wr_idx;
   rect_type    wr_data;
   logic        wr2_en;
   logic [IdxW-1:0] wr2_idx;
   rect_type    wr2_data;

   logic        rsp_valid_in, rsp_valid_ff, rsp_last_ff;
   rect_type    rsp_in, rsp_ff;

   // at the final slot two beats may be pending; split so one goes per cycle
   logic pend_ff, pend_in;
   rect_type pend_r_ff, pend_r_in;

   pair_rel_type rel;
   rect_type    uni;
   rect_type    geo_a;

   // clip math
   logic signed [17:0] cx1, cy1, cx2, cy2, cw, ch;
   logic [CntW-1:0] last_cnt;
   logic [IdxW-1:0] last_idx;
   logic [12:0] fx2, fy2;
   rect_type    fr;
   logic        f_ok;
   logic        last_emit;

   drt_geom u_geom (
      .a         (geo_a),
      .b         (b_ff),
      .merge_gap (gap_ff),
      .rel       (rel),
      .uni       (uni)
   );

   assign geo_a = a_ff;
   assign busy      = (state_ff != ST_IDLE) || pend_ff;
   assign csr_ready = !busy && !start;

   assign last_cnt = count_ff - CntW'(1);
   assign last_idx = last_cnt[IdxW-1:0];

   always_comb begin
      cx1 = {{2{req_rect_x[15]}}, req_rect_x};
      cy1 = {{2{req_rect_y[15]}}, req_rect_y};
      cx2 = cx1 + {{2{req_rect_w[15]}}, req_rect_w};
      cy2 = cy1 + {{2{req_rect_h[15]}}, req_rect_h};
      if (cx1 < 0) cx1 = '0;
      if (cy1 < 0) cy1 = '0;
      if (cx2 > $signed({6'd0, sw_ff})) cx2 = $signed({6'd0, sw_ff});
      if (cy2 > $signed({6'd0, sh_ff})) cy2 = $signed({6'd0, sh_ff});
      cw = cx2 - cx1;
      ch = cy2 - cy1;
   end

   // flush re-clip of a_ff
   always_comb begin
      fr  = a_ff;
      fx2 = {1'b0, a_ff.x} + {1'b0, a_ff.w};
      fy2 = {1'b0, a_ff.y} + {1'b0, a_ff.h};
      f_ok = (a_ff.w != '0) && (a_ff.h != '0);
      if (fx2 > {1'b0, sw_ff}) begin
         f_ok = f_ok && (sw_ff > a_ff.x);
         fr.w = sw_ff - a_ff.x;
      end
      if (fy2 > {1'b0, sh_ff}) begin
         f_ok = f_ok && (sh_ff > a_ff.y);
         fr.h = sh_ff - a_ff.y;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      best_in      = best_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      new_in       = new_ff;
      best_cost_in = best_cost_ff;
      prod_in      = prod_ff;
      old_area_in  = old_area_ff;
      have_in      = have_ff;
      wr_en        = 1'b0;
      wr_idx       = i_ff;
      wr_data      = a_ff;
      wr2_en       = 1'b0;
      wr2_idx      = j_ff;
      wr2_data     = a_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = fr;
      last_emit    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               priority case (action_type'(req_action))
                  ACT_INVALIDATE: begin
                     if (en_ff && !req_rect_w[15] && req_rect_w != '0
                         && !req_rect_h[15] && req_rect_h != '0)
                        state_in = ST_CLIP;
                  end
                  ACT_FLUSH: begin
                     if (en_ff && count_ff != '0) begin
                        i_in     = '0;
                        have_in  = 1'b0;
                        state_in = ST_FLUSH_RD;
                     end else begin
                        count_in = '0;
                     end
                  end
                  ACT_DISCARD: count_in = '0;
                  default: ;
               endcase
               new_in.x = cx1[11:0];
               new_in.y = cy1[11:0];
               new_in.w = cw[11:0];
               new_in.h = ch[11:0];
               if (!(action_type'(req_action) == ACT_INVALIDATE) || cw <= 0 || ch <= 0)
                  new_in = new_ff;
               if (action_type'(req_action) == ACT_INVALIDATE && (cw <= 0 || ch <= 0))
                  state_in = ST_IDLE;
            end
         end
         ST_CLIP: begin
            // new_ff holds the clipped rectangle; scan for a holder
            b_in = new_ff;
            i_in = '0;
            if (count_ff == '0) state_in = ST_APPEND;
            else begin
               a_in     = slots_ff[0];
               state_in = ST_HOLD_SCAN;
            end
         end
         ST_HOLD_SCAN: begin
            if (rel.a_holds_b) state_in = ST_IDLE;
            else if (CntW'(i_ff) == last_cnt) begin
               if (count_ff < CntW'(RECT_SLOTS)) state_in = ST_APPEND;
               else begin
                  i_in         = '0;
                  best_in      = '0;
                  best_cost_in = CostInit;
                  state_in     = ST_COST_RD;
               end
            end else begin
               i_in = i_ff + IdxW'(1);
               a_in = slots_ff[i_ff + IdxW'(1)];
            end
         end
         ST_APPEND: begin
            wr_en    = 1'b1;
            wr_idx   = count_ff[IdxW-1:0];
            wr_data  = new_ff;
            count_in = count_ff + CntW'(1);
            i_in     = '0;
            j_in     = IdxW'(1);
            state_in = ST_PAIR_RD;
         end
         ST_COST_RD: begin
            a_in     = slots_ff[i_ff];
            state_in = ST_COST_MUL;
         end
         ST_COST_MUL: begin
            // union area and old area, both 12x12 products
            prod_in     = 32'({12'd0, uni.w} * {12'd0, uni.h});
            old_area_in = 32'({12'd0, a_ff.w} * {12'd0, a_ff.h});
            state_in    = ST_COST_CMP;
         end
         ST_COST_CMP: begin
            if ((prod_ff - old_area_ff) < best_cost_ff) begin
               best_cost_in = prod_ff - old_area_ff;
               best_in      = i_ff;
            end
            if (CntW'(i_ff) == last_cnt) begin
               a_in     = slots_ff[((prod_ff - old_area_ff) < best_cost_ff) ? i_ff : best_ff];
               state_in = ST_MERGE;
            end else begin
               i_in     = i_ff + IdxW'(1);
               state_in = ST_COST_RD;
            end
         end
         ST_MERGE: begin
            wr_en    = 1'b1;
            wr_idx   = best_ff;
            wr_data  = uni;
            i_in     = '0;
            j_in     = IdxW'(1);
            state_in = ST_PAIR_RD;
         end
         ST_PAIR_RD: begin
            if (count_ff < CntW'(2) || CntW'(i_ff) >= last_cnt) state_in = ST_IDLE;
            else begin
               a_in     = slots_ff[i_ff];
               b_in     = slots_ff[j_ff];
               state_in = ST_PAIR_EVAL;
            end
         end
         ST_PAIR_EVAL: begin
            if (rel.a_holds_b || rel.b_holds_a || rel.near) begin
               if (rel.b_holds_a && !rel.a_holds_b) a_in = b_ff;
               else if (!rel.a_holds_b) a_in = uni;
               state_in = ST_PAIR_MOVE;
            end else begin
               state_in = ST_PAIR_RD;
               if (CntW'(j_ff) == last_cnt) begin
                  i_in = i_ff + IdxW'(1);
                  j_in = i_ff + IdxW'(2);
               end else begin
                  j_in = j_ff + IdxW'(1);
               end
            end
         end
         ST_PAIR_MOVE: begin
            // slot i takes the survivor, the last entry moves into j
            wr_en    = 1'b1;
            wr_idx   = i_ff;
            wr_data  = a_ff;
            wr2_en   = 1'b1;
            wr2_idx  = j_ff;
            wr2_data = slots_ff[last_idx];
            count_in = last_cnt;
            i_in     = '0;
            j_in     = IdxW'(1);
            state_in = ST_PAIR_RD;
         end
         ST_FLUSH_RD: begin
            a_in     = slots_ff[i_ff];
            state_in = ST_FLUSH_EMIT;
         end
         ST_FLUSH_EMIT: begin
            rsp_in = new_ff;
            if (f_ok) begin
               new_in  = fr;
               have_in = 1'b1;
               // emit the held rectangle once a later one is known
               if (have_ff) rsp_valid_in = 1'b1;
            end
            if (CntW'(i_ff) == last_cnt) begin
               count_in = '0;
               state_in = ST_IDLE;
               if (f_ok || have_ff) begin
                  rsp_valid_in = 1'b1;
                  last_emit    = 1'b1;
               end
            end else begin
               i_in     = i_ff + IdxW'(1);
               state_in = ST_FLUSH_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pend_in   = 1'b0;
      pend_r_in = pend_r_ff;
      if (state_ff == ST_FLUSH_EMIT && last_emit && f_ok && have_ff) begin
         pend_in   = 1'b1;
         pend_r_in = fr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         sw_ff        <= 12'd320;
         sh_ff        <= 12'd240;
         gap_ff       <= 8'd5;
         en_ff        <= 1'b1;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         have_ff      <= 1'b0;
      end else begin
         state_ff <= (pend_in) ? ST_IDLE : state_in;
         count_ff <= count_in;
         have_ff  <= have_in;
         pend_ff  <= pend_in;
         rsp_valid_ff <= rsp_valid_in || pend_ff;
         if (csr_valid && csr_ready) begin
            unique case (reg_index_type'(csr_index))
               REG_SCREEN_WIDTH:  sw_ff  <= csr_data;
               REG_SCREEN_HEIGHT: sh_ff  <= csr_data;
               REG_MERGE_GAP:     gap_ff <= csr_data[7:0];
               REG_TRACKING:      en_ff  <= csr_data[0];
            endcase
         end
      end
   end

   logic busy_hold;
   assign busy_hold = pend_ff;

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      best_ff      <= best_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      new_ff       <= new_in;
      best_cost_ff <= best_cost_in;
      prod_ff      <= prod_in;
      old_area_ff  <= old_area_in;
      pend_r_ff    <= pend_r_in;
      if (pend_ff) begin
         rsp_ff      <= pend_r_ff;
         rsp_last_ff <= 1'b1;
      end else begin
         rsp_ff      <= (last_emit && !have_ff) ? fr : rsp_in;
         rsp_last_ff <= last_emit && !(f_ok && have_ff);
      end
      if (wr_en)  slots_ff[wr_idx]  <= wr_data;
      if (wr2_en && (CntW'(wr2_idx) != last_cnt)) slots_ff[wr2_idx] <= wr2_data;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_x    = rsp_ff.x;
   assign rsp_out_y    = rsp_ff.y;
   assign rsp_out_w    = rsp_ff.w;
   assign rsp_out_h    = rsp_ff.h;
   assign rsp_out_last = rsp_last_ff && !busy_hold;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(RECT_SLOTS))
      else $error("slot count beyond table depth");
   a_no_csr_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !csr_ready)
      else $error("register write accepted while busy");
   a_rsp_in_flush: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_FLUSH_EMIT) || $past(pend_ff))
      else $error("result strobe outside flush");
   a_compact_shrinks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PAIR_MOVE |=> count_ff == $past(count_ff) - CntW'(1))
      else $error("compaction did not drop an entry");
`endif

endmodule
